### design/cdf_pkg.sv
// Shared constants, codes and controller/datapath link types for the circle draw engine.
package cdf_pkg;

    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 206;
    localparam int MAX_RADIUS = 127;
    localparam int FB_DEPTH   = SCREEN_W * SCREEN_H;
    localparam int FB_AW      = $clog2(FB_DEPTH);

    localparam int XW    = 9;
    localparam int YW    = 8;
    localparam int PIX_W = 16;
    localparam int CFG_W = 10;
    localparam int CFG_IW = 3;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_ROTATION = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LWIDTH   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LHEIGHT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_XOFFSET  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_YOFFSET  = 3'd4;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_step;
        logic mem_rd;
        logic finish;
    } cdf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic go_scan;
        logic go_read;
        logic scan_last;
        logic pipe_empty;
    } cdf_stat_t;

endpackage

### design/cdf_ctrl.sv
// Controller state machine: clearing pass, command decode, scan, drain, framebuffer read and result strobe.
module cdf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cdf_pkg::cdf_stat_t stat,
    output cdf_pkg::cdf_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import cdf_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if (stat.go_scan)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (stat.go_read)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
        end
    end

endmodule

### design/cdf_datapath.sv
// Datapath: configuration, scan counters, pixel pipeline, framebuffer and dirty box.
module cdf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdf_pkg::cdf_cmd_t             cmd,
    output cdf_pkg::cdf_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [cdf_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [cdf_pkg::CFG_W-1:0]     cfg_data,
    input  logic [1:0]                    opcode,
    input  logic signed [10:0]            center_x,
    input  logic signed [10:0]            center_y,
    input  logic [6:0]                    radius,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [cdf_pkg::XW-1:0]        read_col,
    input  logic [cdf_pkg::YW-1:0]        read_row,
    output logic [cdf_pkg::PIX_W-1:0]     pixel_value,
    output logic                          dirty_flag,
    output logic [cdf_pkg::XW-1:0]        box_left,
    output logic [cdf_pkg::YW-1:0]        box_top,
    output logic [cdf_pkg::XW-1:0]        box_right,
    output logic [cdf_pkg::YW-1:0]        box_bottom,
    output logic                          status
);
    import cdf_pkg::*;

    // Configuration registers.
    logic [1:0]        rot_reg;
    logic [8:0]        lw_reg;
    logic [7:0]        lh_reg;
    logic [9:0]        xoff_reg;
    logic [8:0]        yoff_reg;

    // Command latches.
    logic [1:0]        op_reg;
    logic              reject_reg;
    logic signed [10:0] cx_reg;
    logic signed [10:0] cy_reg;
    logic [6:0]        r_reg;
    logic [13:0]       rsq_reg;
    logic [PIX_W-1:0]  color_reg;
    logic              rd_ok_reg;
    logic [FB_AW-1:0]  rd_addr_reg;
    logic [PIX_W-1:0]  rd_data_reg;

    // Scan counters and clearing counter.
    logic signed [7:0] dx_reg;
    logic signed [7:0] dy_reg;
    logic [FB_AW-1:0]  clr_cnt_reg;

    // Pixel pipeline.
    logic              v1_reg;
    logic [15:0]       dsq_reg;
    logic              clip_reg;
    logic [XW-1:0]     px1_reg;
    logic [YW-1:0]     py1_reg;
    logic              v2_reg;
    logic [15:0]       x2_reg;
    logic [15:0]       y2_reg;
    logic              v3_reg;
    logic [FB_AW-1:0]  addr3_reg;
    logic [XW-1:0]     x3_reg;
    logic [YW-1:0]     y3_reg;

    // Dirty box.
    logic              dv_reg;
    logic [XW-1:0]     dl_reg;
    logic [YW-1:0]     dt_reg;
    logic [XW-1:0]     dr_reg;
    logic [YW-1:0]     db_reg;

    // Result registers.
    logic [PIX_W-1:0]  pix_out_reg;
    logic              flag_out_reg;
    logic [XW-1:0]     l_out_reg;
    logic [YW-1:0]     t_out_reg;
    logic [XW-1:0]     r_out_reg;
    logic [YW-1:0]     b_out_reg;
    logic              st_out_reg;

    logic [PIX_W-1:0]  fb_mem [FB_DEPTH];

    logic signed [12:0] cxe;
    logic signed [12:0] cye;
    logic signed [12:0] re;
    logic signed [12:0] lwe;
    logic signed [12:0] lhe;
    logic               reject_now;
    logic [6:0]         r_clamped;
    logic               rd_ok_now;
    logic signed [7:0]  rs;
    logic               dx_last;
    logic signed [12:0] px_s;
    logic signed [12:0] py_s;
    logic signed [15:0] dxsq;
    logic signed [15:0] dysq;
    logic               clip_now;
    logic [15:0]        x16;
    logic [15:0]        y16;
    logic [15:0]        lw16;
    logic [15:0]        lh16;
    logic [15:0]        xr;
    logic [15:0]        yr;
    logic [15:0]        xo;
    logic [15:0]        yo;
    logic               in_circle;
    logic               phys_ok;
    logic               mem_we;
    logic [FB_AW-1:0]   mem_waddr;
    logic [PIX_W-1:0]   mem_wdata;

    // Rejection test and read address are formed from the request ports at acceptance.
    assign r_clamped = (32'(radius) > MAX_RADIUS) ? 7'(MAX_RADIUS) : radius;
    assign cxe = 13'(center_x);
    assign cye = 13'(center_y);
    assign re  = $signed({6'b0, r_clamped});
    assign lwe = $signed({4'b0, lw_reg});
    assign lhe = $signed({5'b0, lh_reg});
    assign reject_now = ((cxe + re) < 0) || ((cye + re) < 0) ||
                        ((cxe - re) >= lwe) || ((cye - re) >= lhe);
    assign rd_ok_now = (32'(read_col) < SCREEN_W) && (32'(read_row) < SCREEN_H);

    assign stat.go_scan    = (opcode == OP_DRAW) && !reject_now;
    assign stat.go_read    = (opcode == OP_READ);
    assign stat.clear_last = (32'(clr_cnt_reg) == FB_DEPTH - 1);

    assign rs         = $signed({1'b0, r_reg});
    assign dx_last    = (dx_reg == rs);
    assign stat.scan_last  = dx_last && (dy_reg == rs);
    assign stat.pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    // Stage one: squared distance and logical clip.
    assign px_s = 13'(cx_reg) + 13'(dx_reg);
    assign py_s = 13'(cy_reg) + 13'(dy_reg);
    assign dxsq = 16'(dx_reg) * 16'(dx_reg);
    assign dysq = 16'(dy_reg) * 16'(dy_reg);
    assign clip_now = (px_s >= 0) && (px_s < lwe) && (py_s >= 0) && (py_s < lhe);

    // Stage two: rotation and offset, all modulo 2^16.
    assign in_circle = (dsq_reg <= {2'b0, rsq_reg});
    assign x16  = {7'b0, px1_reg};
    assign y16  = {8'b0, py1_reg};
    assign lw16 = {7'b0, lw_reg};
    assign lh16 = {8'b0, lh_reg};

    always_comb
    begin
        case (rot_reg)
            ROT_90:
            begin
                xr = lw16 - 16'd1 - y16;
                yr = x16;
            end
            ROT_180:
            begin
                xr = lw16 - 16'd1 - x16;
                yr = lh16 - 16'd1 - y16;
            end
            ROT_270:
            begin
                xr = y16;
                yr = lh16 - 16'd1 - x16;
            end
            default:
            begin
                xr = x16;
                yr = y16;
            end
        endcase
    end

    assign xo = xr + {{6{xoff_reg[9]}}, xoff_reg};
    assign yo = yr + {{7{yoff_reg[8]}}, yoff_reg};

    // Stage three: physical bounds.
    assign phys_ok = (32'(x2_reg) < SCREEN_W) && (32'(y2_reg) < SCREEN_H);

    assign mem_we    = cmd.clear_step || v3_reg;
    assign mem_waddr = cmd.clear_step ? clr_cnt_reg : addr3_reg;
    assign mem_wdata = cmd.clear_step ? '0 : color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fb_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= fb_mem[rd_addr_reg];
        end
    end

    // Payload latches need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg      <= center_x;
            cy_reg      <= center_y;
            r_reg       <= r_clamped;
            rsq_reg     <= 14'(r_clamped) * 14'(r_clamped);
            color_reg   <= {red[7:3], green[7:2], blue[7:3]};
            rd_ok_reg   <= rd_ok_now;
            rd_addr_reg <= rd_ok_now ?
                           (FB_AW'(read_row) * FB_AW'(SCREEN_W) + FB_AW'(read_col)) : '0;
        end
        dsq_reg   <= 16'(dxsq) + 16'(dysq);
        clip_reg  <= clip_now;
        px1_reg   <= px_s[XW-1:0];
        py1_reg   <= py_s[YW-1:0];
        x2_reg    <= xo;
        y2_reg    <= yo;
        x3_reg    <= x2_reg[XW-1:0];
        y3_reg    <= y2_reg[YW-1:0];
        addr3_reg <= FB_AW'(y2_reg[YW-1:0]) * FB_AW'(SCREEN_W) + FB_AW'(x2_reg[XW-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg      <= ROT_180;
            lw_reg       <= 9'(SCREEN_W);
            lh_reg       <= 8'(SCREEN_H);
            xoff_reg     <= '0;
            yoff_reg     <= '0;
            op_reg       <= OP_DRAW;
            reject_reg   <= 1'b0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            clr_cnt_reg  <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            dv_reg       <= 1'b0;
            dl_reg       <= XW'(SCREEN_W);
            dt_reg       <= YW'(SCREEN_H);
            dr_reg       <= '0;
            db_reg       <= '0;
            pix_out_reg  <= '0;
            flag_out_reg <= 1'b0;
            l_out_reg    <= '0;
            t_out_reg    <= '0;
            r_out_reg    <= '0;
            b_out_reg    <= '0;
            st_out_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROTATION: rot_reg  <= cfg_data[1:0];
                    CFG_LWIDTH:   lw_reg   <= cfg_data[8:0];
                    CFG_LHEIGHT:  lh_reg   <= cfg_data[7:0];
                    CFG_XOFFSET:  xoff_reg <= cfg_data[9:0];
                    CFG_YOFFSET:  yoff_reg <= cfg_data[8:0];
                    default:      ;
                endcase
            end

            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end

            if (cmd.load)
            begin
                op_reg     <= opcode;
                reject_reg <= reject_now;
                dx_reg     <= -$signed({1'b0, r_clamped});
                dy_reg     <= -$signed({1'b0, r_clamped});
            end
            else if (cmd.scan_step)
            begin
                if (dx_last)
                begin
                    dx_reg <= -rs;
                    dy_reg <= dy_reg + 8'sd1;
                end
                else
                begin
                    dx_reg <= dx_reg + 8'sd1;
                end
            end

            v1_reg <= cmd.scan_step;
            v2_reg <= v1_reg && clip_reg && in_circle;
            v3_reg <= v2_reg && phys_ok;

            if (v3_reg)
            begin
                dv_reg <= 1'b1;
                if (x3_reg < dl_reg) dl_reg <= x3_reg;
                if (x3_reg > dr_reg) dr_reg <= x3_reg;
                if (y3_reg < dt_reg) dt_reg <= y3_reg;
                if (y3_reg > db_reg) db_reg <= y3_reg;
            end

            if (cmd.finish)
            begin
                pix_out_reg  <= (op_reg == OP_READ && rd_ok_reg) ? rd_data_reg : '0;
                flag_out_reg <= dv_reg;
                l_out_reg    <= dl_reg;
                t_out_reg    <= dt_reg;
                r_out_reg    <= dr_reg;
                b_out_reg    <= db_reg;
                st_out_reg   <= (op_reg == OP_DRAW) && reject_reg;
                // The take command reports the box as it stood and then empties it.
                if (op_reg == OP_TAKE)
                begin
                    dv_reg <= 1'b0;
                    dl_reg <= XW'(SCREEN_W);
                    dt_reg <= YW'(SCREEN_H);
                    dr_reg <= '0;
                    db_reg <= '0;
                end
            end
        end
    end

    assign pixel_value = pix_out_reg;
    assign dirty_flag  = flag_out_reg;
    assign box_left    = l_out_reg;
    assign box_top     = t_out_reg;
    assign box_right   = r_out_reg;
    assign box_bottom  = b_out_reg;
    assign status      = st_out_reg;

endmodule

### design/circle_draw_framebuffer_core.sv
// Top level of the filled circle draw engine with framebuffer and dirty box.
//
// Commands are taken on start while busy is low: draw a filled circle (opcode draw),
// read one stored RGB565 pixel (opcode read), or report and empty the dirty box
// (opcode take). Each command gives one result beat, shown for a single cycle with
// done high; the receiver cannot stall it, and the next command may be started in
// the same cycle that done is high.
// Configuration (rotation, logical size, offsets) is written through cfg_we,
// cfg_index and cfg_data at any time; it should only change while the block is idle.
// A draw tests one pixel per cycle in the scan loop, then waits for the three-stage pixel
// pipeline to drain and registers the result; a read performs a registered framebuffer
// read; take, a rejected draw and the unused opcode go straight to the result beat.
// One command is in flight at a time.
// After reset the framebuffer is swept to zero one word per cycle, while busy stays high and
// no command is taken.
module circle_draw_framebuffer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic                          cfg_we,
    input  logic [cdf_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [cdf_pkg::CFG_W-1:0]     cfg_data,
    input  logic [1:0]                    opcode,
    input  logic signed [10:0]            center_x,
    input  logic signed [10:0]            center_y,
    input  logic [6:0]                    radius,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [cdf_pkg::XW-1:0]        read_col,
    input  logic [cdf_pkg::YW-1:0]        read_row,
    output logic [cdf_pkg::PIX_W-1:0]     pixel_value,
    output logic                          dirty_flag,
    output logic [cdf_pkg::XW-1:0]        box_left,
    output logic [cdf_pkg::YW-1:0]        box_top,
    output logic [cdf_pkg::XW-1:0]        box_right,
    output logic [cdf_pkg::YW-1:0]        box_bottom,
    output logic                          status
);
    import cdf_pkg::*;

    cdf_cmd_t  cmd;
    cdf_stat_t stat;

    cdf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    cdf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .read_col    (read_col),
        .read_row    (read_row),
        .pixel_value (pixel_value),
        .dirty_flag  (dirty_flag),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .status      (status)
    );

endmodule

### design/cdf_checker.sv
// Port-level checker for the circle draw engine, bound to the top level.
module cdf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       dirty_flag,
    input logic [cdf_pkg::XW-1:0]     box_left,
    input logic [cdf_pkg::YW-1:0]     box_top,
    input logic [cdf_pkg::XW-1:0]     box_right,
    input logic [cdf_pkg::YW-1:0]     box_bottom
);
    import cdf_pkg::*;

    // A result beat only appears once the engine has gone back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat while engine busy or without prior work");

    // An accepted command always takes the engine out of idle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but engine did not go busy");

    // Each command yields a single beat.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A clean box always reports its reset corners.
    a_clean_box: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !dirty_flag) |->
            (32'(box_left) == SCREEN_W) && (32'(box_top) == SCREEN_H) &&
            (box_right == '0) && (box_bottom == '0))
        else $error("clean dirty box does not hold its reset values");

endmodule

bind circle_draw_framebuffer_core cdf_checker u_cdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .dirty_flag (dirty_flag),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom)
);
